// ===== rtl/core/pmp_pkg.sv =====
// pmp_pkg: payload types, controller states and command/status structs
// for the pose motion predictor. No dependencies.
package pmp_pkg;

   localparam int QONE = 16384;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [15:0] quat_w;
      logic signed [15:0] quat_x;
      logic signed [15:0] quat_y;
      logic signed [15:0] quat_z;
   } req_type;

   typedef struct packed {
      logic signed [31:0] pred_x;
      logic signed [31:0] pred_y;
      logic signed [31:0] pred_z;
      logic signed [15:0] pred_qw;
      logic signed [15:0] pred_qx;
      logic signed [15:0] pred_qy;
      logic signed [15:0] pred_qz;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL1,
      ST_DOT,
      ST_NORM1,
      ST_MUL2,
      ST_NORM2,
      ST_DONE
   } state_type;

   // norm unit phases inside the datapath
   typedef enum logic [2:0] {
      NP_SQ,
      NP_SUM,
      NP_SQRT,
      NP_DIV,
      NP_FIN
   } nphase_type;

   typedef struct packed {
      logic load;      // capture input pose, restart product step
      logic mul_start; // step product lane
      logic sel_second;// product operand: 0 cur*conj(prev), 1 cur*nav
      logic dot;       // compute blend sum, update linear state
      logic norm_start;
      logic commit;    // store angular state
      logic publish;   // write result register
   } cmd_type;

   typedef struct packed {
      logic mul_done;
      logic norm_done;
   } sts_type;

endpackage

// ===== rtl/core/pmp_ctrl.sv =====
// pmp_ctrl: sequencing state machine for the pose motion predictor.
// Depends on pmp_pkg.
module pmp_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output pmp_pkg::cmd_type cmd,
   input  pmp_pkg::sts_type sts
);
   pmp_pkg::state_type state_ff, state_in;
   logic               full_ff, full_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pmp_pkg::ST_IDLE;
         full_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         full_ff  <= full_in;
      end
   end

   assign rsp_valid = full_ff;
   assign req_stall = (state_ff != pmp_pkg::ST_IDLE);

   always_comb begin
      state_in = state_ff;
      full_in  = full_ff && rsp_stall;
      cmd      = '0;
      case (state_ff)
         pmp_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = pmp_pkg::ST_MUL1;
            end
         end
         pmp_pkg::ST_MUL1: begin
            cmd.mul_start = 1'b1;
            if (sts.mul_done) state_in = pmp_pkg::ST_DOT;
         end
         pmp_pkg::ST_DOT: begin
            cmd.dot = 1'b1;
            state_in = pmp_pkg::ST_NORM1;
         end
         pmp_pkg::ST_NORM1: begin
            cmd.norm_start = 1'b1;
            if (sts.norm_done) begin
               cmd.commit = 1'b1;
               state_in = pmp_pkg::ST_MUL2;
            end
         end
         pmp_pkg::ST_MUL2: begin
            cmd.mul_start  = 1'b1;
            cmd.sel_second = 1'b1;
            if (sts.mul_done) state_in = pmp_pkg::ST_NORM2;
         end
         pmp_pkg::ST_NORM2: begin
            cmd.norm_start = 1'b1;
            cmd.sel_second = 1'b1;
            if (sts.norm_done) state_in = pmp_pkg::ST_DONE;
         end
         pmp_pkg::ST_DONE: begin
            if (!full_in) begin
               cmd.publish = 1'b1;
               full_in  = 1'b1;
               state_in = pmp_pkg::ST_IDLE;
            end
         end
         default: state_in = pmp_pkg::ST_IDLE;
      endcase
   end
endmodule

// ===== rtl/core/pmp_norm.sv =====
// pmp_norm: iterative normaliser of a Q.28 quaternion into Q1.14.
// Square sum, bit-serial square root, then restoring divides. Uses pmp_pkg.
module pmp_norm (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [35:0] vec [4],
   output logic               done,
   output logic signed [15:0] res [4]
);
   pmp_pkg::nphase_type ph_ff;
   logic              busy_ff;
   logic [32:0]       mag_ff [4];
   logic [3:0]        neg_ff;
   logic [65:0]       sq_ff  [4];
   logic [67:0]       n2_ff;
   logic [67:0]       rem_ff;
   logic [34:0]       root_ff;
   logic [5:0]        cnt_ff;
   logic [1:0]        lane_ff;
   logic [47:0]       num_ff;
   logic [34:0]       drem_ff;
   logic [15:0]       q_ff;
   logic signed [15:0] res_ff [4];
   logic              done_ff;

   logic [69:0] trial;
   logic [35:0] dtrial;
   logic [35:0] tmp [4];
   logic [15:0] qfin;
   logic [15:0] qsat;
   logic        last_div;
   logic        fin_now;

   assign res  = res_ff;
   assign done = done_ff;
   assign trial  = {rem_ff, n2_ff[67:66]} - {33'd0, root_ff, 2'b01};
   assign dtrial = {drem_ff, num_ff[47]} - {1'b0, root_ff};
   assign qfin   = {q_ff[14:0], ~dtrial[35]};
   assign qsat   = (q_ff[15] || q_ff >= 16'd8192) ? 16'd16384 : qfin;
   assign last_div = (ph_ff == pmp_pkg::NP_DIV) && (cnt_ff == 6'd1) && (lane_ff == 2'd3);
   assign fin_now  = busy_ff && (last_div ||
                     ((ph_ff == pmp_pkg::NP_FIN) && (root_ff == '0)));

   always_comb begin
      for (int i = 0; i < 4; i++)
         tmp[i] = vec[i][35] ? 36'(-vec[i]) : 36'(vec[i]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         ph_ff   <= pmp_pkg::NP_SQ;
      end else begin
         done_ff <= fin_now;
         if (!busy_ff) begin
            if (start && !done_ff) begin
               busy_ff <= 1'b1;
               ph_ff   <= pmp_pkg::NP_SQ;
               for (int i = 0; i < 4; i++) begin
                  mag_ff[i] <= tmp[i][34:2];
                  neg_ff[i] <= vec[i][35];
               end
            end
         end else begin
            case (ph_ff)
               pmp_pkg::NP_SQ: begin
                  for (int i = 0; i < 4; i++) sq_ff[i] <= mag_ff[i] * mag_ff[i];
                  ph_ff <= pmp_pkg::NP_SUM;
               end
               pmp_pkg::NP_SUM: begin
                  n2_ff   <= 68'(sq_ff[0]) + 68'(sq_ff[1]) + 68'(sq_ff[2]) + 68'(sq_ff[3]);
                  rem_ff  <= '0;
                  root_ff <= '0;
                  cnt_ff  <= 6'd34;
                  ph_ff   <= pmp_pkg::NP_SQRT;
               end
               pmp_pkg::NP_SQRT: begin
                  // one result bit per cycle
                  if (!trial[69]) begin
                     rem_ff  <= trial[67:0];
                     root_ff <= {root_ff[33:0], 1'b1};
                  end else begin
                     rem_ff  <= {rem_ff[65:0], n2_ff[67:66]};
                     root_ff <= {root_ff[33:0], 1'b0};
                  end
                  n2_ff  <= {n2_ff[65:0], 2'b00};
                  cnt_ff <= cnt_ff - 6'd1;
                  if (cnt_ff == 6'd1) begin
                     lane_ff <= '0;
                     ph_ff   <= pmp_pkg::NP_FIN;
                  end
               end
               pmp_pkg::NP_FIN: begin
                  if (root_ff == '0) begin
                     res_ff[0] <= 16'sd16384;
                     for (int i = 1; i < 4; i++) res_ff[i] <= '0;
                     busy_ff <= 1'b0;
                  end else begin
                     num_ff  <= 48'({mag_ff[lane_ff], 14'd0}) + 48'(root_ff[34:1]);
                     drem_ff <= '0;
                     q_ff    <= '0;
                     cnt_ff  <= 6'd48;
                     ph_ff   <= pmp_pkg::NP_DIV;
                  end
               end
               pmp_pkg::NP_DIV: begin
                  if (!dtrial[35]) drem_ff <= dtrial[34:0];
                  else             drem_ff <= {drem_ff[33:0], num_ff[47]};
                  q_ff   <= (q_ff[15] || q_ff > 16'd16383) ? 16'h8000 : qfin;
                  num_ff <= {num_ff[46:0], 1'b0};
                  cnt_ff <= cnt_ff - 6'd1;
                  if (cnt_ff == 6'd1) begin
                     res_ff[lane_ff] <= neg_ff[lane_ff] ? -$signed(qsat) : $signed(qsat);
                     if (lane_ff == 2'd3) begin
                        busy_ff <= 1'b0;
                     end else begin
                        lane_ff <= lane_ff + 2'd1;
                        ph_ff   <= pmp_pkg::NP_FIN;
                     end
                  end
               end
               default: ph_ff <= pmp_pkg::NP_SQ;
            endcase
         end
      end
   end
endmodule

// ===== rtl/core/pmp_datapath.sv =====
// pmp_datapath: pose state, velocity, quaternion product lane and blend.
// Depends on pmp_pkg and pmp_norm.
module pmp_datapath (
   input  logic              clock,
   input  logic              reset,
   input  pmp_pkg::req_type  req_data,
   input  pmp_pkg::cmd_type  cmd,
   output pmp_pkg::sts_type  sts,
   output pmp_pkg::rsp_type  rsp_data
);
   logic signed [31:0] ppos_ff [3];
   logic signed [31:0] vel_ff  [3];
   logic signed [15:0] pq_ff   [4];
   logic signed [15:0] av_ff   [4];
   logic signed [31:0] pos_ff  [3];
   logic signed [15:0] cur_ff  [4];
   logic signed [35:0] prod_ff [4];
   logic signed [35:0] s_ff    [4];
   logic signed [32:0] term_ff;
   logic [4:0]         k_ff;
   logic               kneg_ff;
   pmp_pkg::rsp_type   rsp_ff;

   logic signed [16:0] b [4];
   logic signed [15:0] a_op;
   logic signed [16:0] b_op;
   logic               neg_t;
   logic [1:0]         comp, ai;
   logic [4:0]         km1;
   logic signed [15:0] nres [4];
   logic signed [35:0] nvec [4];
   logic               ndone;
   logic signed [63:0] dot;
   logic signed [33:0] vsum [3];

   function automatic logic signed [31:0] sat(input logic signed [33:0] x);
      if (x > 34'sd2147483647)       return 32'sh7fffffff;
      else if (x < -34'sd2147483648) return 32'sh80000000;
      else                           return x[31:0];
   endfunction

   always_comb begin
      if (cmd.sel_second) begin
         for (int i = 0; i < 4; i++) b[i] = 17'(av_ff[i]);
      end else begin
         b[0] = 17'(pq_ff[0]);
         for (int i = 1; i < 4; i++) b[i] = -17'(pq_ff[i]);
      end
   end

   // step k: component k[3:2], a index k[1:0], b index a ^ component
   always_comb begin
      comp = k_ff[3:2];
      ai   = k_ff[1:0];
      neg_t = 1'b0;
      case ({comp, ai})
         4'b0001, 4'b0010, 4'b0011: neg_t = 1'b1;
         4'b0111: neg_t = 1'b1;
         4'b1001: neg_t = 1'b1;
         4'b1110: neg_t = 1'b1;
         default: neg_t = 1'b0;
      endcase
      a_op = cur_ff[ai];
      b_op = b[ai ^ comp];
   end

   assign km1 = k_ff - 5'd1;

   always_comb begin
      dot = '0;
      for (int i = 0; i < 4; i++) dot = dot + 64'(prod_ff[i]) * 64'(av_ff[i]);
      for (int i = 0; i < 3; i++) begin
         vsum[i] = 34'(pos_ff[i]) - 34'(ppos_ff[i]) + 34'(vel_ff[i]);
      end
      for (int i = 0; i < 4; i++) nvec[i] = cmd.sel_second ? prod_ff[i] : s_ff[i];
   end

   pmp_norm u_norm (
      .clock (clock),
      .reset (reset),
      .start (cmd.norm_start),
      .vec   (nvec),
      .done  (ndone),
      .res   (nres)
   );

   assign sts.norm_done = ndone;
   assign sts.mul_done  = (k_ff == 5'd17);
   assign rsp_data      = rsp_ff;

   always_ff @(posedge clock) kneg_ff <= neg_t;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            ppos_ff[i] <= '0;
            vel_ff[i]  <= '0;
         end
         for (int i = 0; i < 4; i++) begin
            pq_ff[i] <= (i == 0) ? 16'sd16384 : '0;
            av_ff[i] <= (i == 0) ? 16'sd16384 : '0;
         end
         k_ff <= '0;
      end else begin
         if (cmd.load) begin
            pos_ff[0] <= req_data.pos_x;
            pos_ff[1] <= req_data.pos_y;
            pos_ff[2] <= req_data.pos_z;
            cur_ff[0] <= req_data.quat_w;
            cur_ff[1] <= req_data.quat_x;
            cur_ff[2] <= req_data.quat_y;
            cur_ff[3] <= req_data.quat_z;
            k_ff <= '0;
         end
         if (cmd.mul_start) begin
            // one multiply per cycle, registered, then accumulated
            if (k_ff < 5'd16) term_ff <= a_op * b_op;
            if (k_ff != 5'd0 && k_ff < 5'd17) begin
               prod_ff[km1[3:2]] <= ((km1[1:0] == 2'd0) ? 36'sd0 : prod_ff[km1[3:2]]) +
                                    (kneg_ff ? -36'(term_ff) : 36'(term_ff));
            end
            if (k_ff == 5'd17) k_ff <= '0;
            else               k_ff <= k_ff + 5'd1;
         end
         if (cmd.dot) begin
            for (int i = 0; i < 4; i++)
               s_ff[i] <= (dot >= 0) ? prod_ff[i] + (36'(av_ff[i]) <<< 14)
                                     : prod_ff[i] - (36'(av_ff[i]) <<< 14);
            for (int i = 0; i < 3; i++) begin
               vel_ff[i]  <= sat(vsum[i] >>> 1);
               ppos_ff[i] <= pos_ff[i];
            end
         end
         if (cmd.commit) begin
            for (int i = 0; i < 4; i++) begin
               av_ff[i] <= nres[i];
               pq_ff[i] <= cur_ff[i];
            end
         end
         if (cmd.publish) begin
            rsp_ff.pred_x  <= sat(34'(pos_ff[0]) + 34'(vel_ff[0]));
            rsp_ff.pred_y  <= sat(34'(pos_ff[1]) + 34'(vel_ff[1]));
            rsp_ff.pred_z  <= sat(34'(pos_ff[2]) + 34'(vel_ff[2]));
            rsp_ff.pred_qw <= nres[0];
            rsp_ff.pred_qx <= nres[1];
            rsp_ff.pred_qy <= nres[2];
            rsp_ff.pred_qz <= nres[3];
         end
      end
   end
endmodule

// ===== rtl/core/pose_motion_predictor.sv =====
// pose_motion_predictor: top level, controller plus datapath.
// Depends on pmp_pkg, pmp_ctrl, pmp_datapath.
//
//   channel   direction  handshake          payload
//   req_      in         req_valid/stall    pmp_pkg::req_type
//   rsp_      out        rsp_valid/stall    pmp_pkg::rsp_type
//
// Per pose: accept, two product passes on one multiplier, blend, two
// normalisations (square, sum, 34-step root, four lane divides, done),
// publish; a zero vector skips the divides.
// Input stalls from accept until publish. Reset gives zero position/velocity,
// identity orientations. A held result stalls nothing until the next pose completes.
module pose_motion_predictor (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  pmp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output pmp_pkg::rsp_type rsp_data
);
   pmp_pkg::cmd_type cmd;
   pmp_pkg::sts_type sts;

   pmp_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .cmd(cmd), .sts(sts)
   );

   pmp_datapath u_dp (
      .clock(clock), .reset(reset), .req_data(req_data), .cmd(cmd), .sts(sts),
      .rsp_data(rsp_data)
   );
endmodule
